### rtl/core/stq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Widths, codes and the list entry type shared by the timer queue files.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int MAX_FIRE   = 16;

   localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W  = $clog2(NUM_TIMERS + 1);
   localparam int FIRE_W = $clog2(MAX_FIRE + 1);

   localparam int MODE_W  = 2;
   localparam int ID_W    = 4;
   localparam int DELAY_W = 32;
   localparam int TIME_W  = 64;
   localparam int KIND_W  = 2;

   localparam logic [TIME_W-1:0] EXPIRY_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_SET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

   // One list position: the absolute expiry and the timer slot it belongs to.
   typedef struct packed {
      logic [TIME_W-1:0] expiry;
      logic [IDX_W-1:0]  slot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### rtl/core/stq_req_if.sv
// ----------------------------------------------------------------------------
// Timer queue request channel
// Valid/ready channel that carries one set, cancel or tick request word.
// ----------------------------------------------------------------------------
interface stq_req_if import stq_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [ID_W-1:0]      timer_id;
   logic [DELAY_W-1:0]   delay;
   logic [TIME_W-1:0]    now;

   modport source (output valid, mode, timer_id, delay, now, input ready);
   modport sink   (input valid, mode, timer_id, delay, now, output ready);

endinterface

### rtl/core/stq_rsp_if.sv
// ----------------------------------------------------------------------------
// Timer queue response channel
// Valid/ready channel that carries one acknowledge or expiry word.
// ----------------------------------------------------------------------------
interface stq_rsp_if import stq_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     fired_id;
   logic                last;

   modport source (output valid, kind, fired_id, last, input ready);
   modport sink   (input valid, kind, fired_id, last, output ready);

endinterface

### rtl/core/stq_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/sorted_timer_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted timer queue core
// Keeps the active timers in a list ordered by absolute expiry, earliest
// first, and fires the front entries that are due on a tick.
//
//   channel  dir  word contents                      handshake
//   req_if   in   mode, timer_id, delay, now         valid/ready
//   rsp_if   out  kind, fired_id, last               valid/ready
//
// The list is a circular buffer in one RAM; a head pointer makes a pop free.
// Cancel of an active timer takes one compaction pass.
// Set takes that pass (if the timer was active) plus a backward insert pass.
// Tick pops the due front entries one after another, up to MAX_FIRE of them.
// Reset is synchronous and empties the list at once; no clearing pass.
// A full response register holds the sequencer wherever it has a word to give.
// ----------------------------------------------------------------------------
module sorted_timer_queue_core
   import stq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   stq_req_if.sink   req_if,
   stq_rsp_if.source rsp_if
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_DROP  = 5'b00010,
      ST_INS   = 5'b00100,
      ST_ACK   = 5'b01000,
      ST_TCHK  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [NUM_TIMERS-1:0] flags_ff, flags_in;

   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [TIME_W-1:0]   exp_ff, exp_in;
   logic [TIME_W-1:0]   now_ff, now_in;

   logic [CNT_W-1:0]    rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]    dpos_ff, dpos_in;
   logic [CNT_W-1:0]    wr_pos_ff, wr_pos_in;
   logic                dv_ff, dv_in;
   logic                found_ff, found_in;

   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [FIRE_W-1:0]   fire_cnt_ff, fire_cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   entry_type           ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd_entry;

   logic                req_acc;
   logic                can_emit;
   logic [TIME_W:0]     sum;
   logic [TIME_W-1:0]   new_exp;
   logic                in_range;
   logic [IDX_W-1:0]    req_slot;
   logic                fires;
   logic                need_emit;
   logic                ins_done;

   // List position to RAM address, wrapping around the circular buffer.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
                                             input logic [CNT_W-1:0] p);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(h) + (CNT_W+1)'(p);
      if (s >= (CNT_W+1)'(NUM_TIMERS)) begin
         s = s - (CNT_W+1)'(NUM_TIMERS);
      end
      return IDX_W'(s);
   endfunction

   stq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_TIMERS)
   ) u_list_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry = entry_type'(ram_rdata);

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_if.valid && req_if.ready;
   assign can_emit     = !rsp_valid_ff || rsp_if.ready;

   // Saturating absolute expiry.
   assign sum      = {1'b0, req_if.now} + {{(TIME_W + 1 - DELAY_W){1'b0}}, req_if.delay};
   assign new_exp  = sum[TIME_W] ? EXPIRY_MAX : sum[TIME_W-1:0];
   assign in_range = (32'(req_if.timer_id) < NUM_TIMERS);
   assign req_slot = IDX_W'(req_if.timer_id);

   assign fires = (count_ff != '0) && (rd_entry.expiry <= now_ff)
                  && (fire_cnt_ff < FIRE_W'(MAX_FIRE));
   assign need_emit = pend_ff || !fires;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      flags_in     = flags_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      slot_in      = slot_ff;
      exp_in       = exp_ff;
      now_in       = now_ff;
      rd_pos_in    = rd_pos_ff;
      dpos_in      = dpos_ff;
      wr_pos_in    = wr_pos_ff;
      dv_in        = 1'b0;
      found_in     = found_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      fire_cnt_in  = fire_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = head_ff;
      ram_wdata    = '{expiry: exp_ff, slot: slot_ff};
      ram_raddr    = head_ff;
      ins_done     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               mode_in   = req_if.mode;
               id_in     = req_if.timer_id;
               slot_in   = req_slot;
               exp_in    = new_exp;
               now_in    = req_if.now;
               rd_pos_in = '0;
               wr_pos_in = '0;
               found_in  = 1'b0;
               priority if (req_if.mode == MODE_TICK) begin
                  // The head read goes out on this edge through the default address.
                  fire_cnt_in = '0;
                  pend_in     = 1'b0;
                  state_in    = ST_TCHK;
               end else if (in_range && flags_ff[req_slot]
                            && (req_if.mode == MODE_SET || req_if.mode == MODE_CANCEL)) begin
                  state_in = ST_DROP;
               end else if (in_range && req_if.mode == MODE_SET) begin
                  rd_pos_in = count_ff;
                  state_in  = ST_INS;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end

         ST_DROP: begin
            // Compaction: every entry but the dropped one moves to the write position.
            if (dv_ff) begin
               if (rd_entry.slot == slot_ff && !found_ff) begin
                  found_in = 1'b1;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = phys(head_ff, wr_pos_ff);
                  ram_wdata = rd_entry;
                  wr_pos_in = wr_pos_ff + CNT_W'(1);
               end
            end
            if (rd_pos_ff != count_ff) begin
               ram_raddr = phys(head_ff, rd_pos_ff);
               rd_pos_in = rd_pos_ff + CNT_W'(1);
               dv_in     = 1'b1;
            end else if (!dv_ff) begin
               count_in          = count_ff - CNT_W'(1);
               flags_in[slot_ff] = 1'b0;
               if (mode_ff == MODE_SET) begin
                  rd_pos_in = count_ff - CNT_W'(1);
                  state_in  = ST_INS;
               end else begin
                  state_in = ST_ACK;
               end
            end
         end

         ST_INS: begin
            // Backward walk: later entries shift up until one expires no later.
            if (dv_ff) begin
               ram_we    = 1'b1;
               ram_waddr = phys(head_ff, dpos_ff + CNT_W'(1));
               if (rd_entry.expiry > exp_ff) begin
                  ram_wdata = rd_entry;
               end else begin
                  ins_done = 1'b1;
               end
            end else if (rd_pos_ff == '0) begin
               ram_we    = 1'b1;
               ram_waddr = head_ff;
               ins_done  = 1'b1;
            end
            if (!ins_done && rd_pos_ff != '0) begin
               ram_raddr = phys(head_ff, rd_pos_ff - CNT_W'(1));
               dpos_in   = rd_pos_ff - CNT_W'(1);
               rd_pos_in = rd_pos_ff - CNT_W'(1);
               dv_in     = 1'b1;
            end
            if (ins_done) begin
               count_in          = count_ff + CNT_W'(1);
               flags_in[slot_ff] = 1'b1;
               state_in          = ST_ACK;
            end
         end

         ST_ACK: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_id_in    = id_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_TCHK: begin
            // A fired timer is held back until the next head is checked so that its last flag is known.
            if (!need_emit || can_emit) begin
               if (need_emit) begin
                  rsp_valid_in = 1'b1;
                  if (pend_ff) begin
                     rsp_kind_in = KIND_FIRED;
                     rsp_id_in   = ID_W'(pend_slot_ff);
                     rsp_last_in = !fires;
                  end else begin
                     rsp_kind_in = KIND_NONE;
                     rsp_id_in   = '0;
                     rsp_last_in = 1'b1;
                  end
               end
               if (fires) begin
                  head_in                 = phys(head_ff, CNT_W'(1));
                  ram_raddr               = phys(head_ff, CNT_W'(1));
                  count_in                = count_ff - CNT_W'(1);
                  flags_in[rd_entry.slot] = 1'b0;
                  pend_in                 = 1'b1;
                  pend_slot_in            = rd_entry.slot;
                  fire_cnt_in             = fire_cnt_ff + FIRE_W'(1);
               end else begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         flags_ff     <= '0;
         dv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         flags_ff     <= flags_in;
         dv_ff        <= dv_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      id_ff        <= id_in;
      slot_ff      <= slot_in;
      exp_ff       <= exp_in;
      now_ff       <= now_in;
      rd_pos_ff    <= rd_pos_in;
      dpos_ff      <= dpos_in;
      wr_pos_ff    <= wr_pos_in;
      pend_slot_ff <= pend_slot_in;
      fire_cnt_ff  <= fire_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.kind     = rsp_kind_ff;
   assign rsp_if.fired_id = rsp_id_ff;
   assign rsp_if.last     = rsp_last_ff;

   // The list never holds more entries than there are timers.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUM_TIMERS))
      else $error("active count exceeds the number of timers");

   // Between requests the active flags and the list length agree.
   a_flags_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(flags_ff) == 32'(count_ff)))
      else $error("active flags disagree with the active count");

   // No held-back expiry word survives the end of a tick.
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("pending expiry word left over after a tick");

   // Only the compaction and insert passes write the list.
   a_write_pass: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_DROP || state_ff == ST_INS))
      else $error("list write outside a list pass");

   // An insert always finds room.
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS) |-> (count_ff < CNT_W'(NUM_TIMERS)))
      else $error("insert into a full list");

endmodule
